/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the PPM frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ppmfd_pkg.sv */
// Types and constants shared by the PPM frame decoder modules.
package ppmfd_pkg;

    localparam int unsigned GAP_W      = 8;
    localparam int unsigned COARSE_W   = 32;
    localparam int unsigned FINE_W     = 8;
    localparam int unsigned SLOT_W     = 3;
    localparam int unsigned INTERVAL_W = 32;
    localparam int unsigned SYNC_W     = 8;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 48;
    localparam logic [GAP_W-1:0] SYNC_GAP_RESET = 8'd30;

    typedef enum logic [0:0] {
        ACT_EDGE = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_IGNORED = 2'd0,
        KIND_SYNC    = 2'd1,
        KIND_STORED  = 2'd2,
        KIND_READ    = 2'd3
    } event_kind_t;

    // Result of one word as decided by the frame tracker.
    typedef struct packed {
        event_kind_t             kind;
        logic [SLOT_W-1:0]       slot_index;
        logic [INTERVAL_W-1:0]   interval;
        logic [SYNC_W-1:0]       sync_total;
        logic                    wr_en;
    } ppmfd_evt_t;

endpackage

/* rtl/ppmfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ppmfd_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 8,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ppmfd_track.sv */
// Frame tracker: sync detection, slot pointer, last edge time and sync count.
module ppmfd_track
    import ppmfd_pkg::*;
#(
    parameter int unsigned CHANNELS = 8,
    parameter int unsigned ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [GAP_W-1:0]      cfg_wr_data,
    input  logic                  accept,
    input  action_t               action,
    input  logic [COARSE_W-1:0]   coarse_time,
    input  logic [FINE_W-1:0]     fine_time,
    input  logic [SLOT_W-1:0]     read_slot,
    output ppmfd_evt_t            evt,
    output logic [ADDR_W-1:0]     wr_addr
);

    localparam int unsigned PTR_W = $clog2(CHANNELS + 1);

    logic [GAP_W-1:0]    sync_gap_reg,    sync_gap_next;
    logic [COARSE_W-1:0] last_coarse_reg, last_coarse_next;
    logic [FINE_W-1:0]   last_fine_reg,   last_fine_next;
    logic                in_sync_reg,     in_sync_next;
    logic [PTR_W-1:0]    next_slot_reg,   next_slot_next;
    logic [SYNC_W-1:0]   sync_cnt_reg,    sync_cnt_next;

    logic [COARSE_W-1:0]   gap;
    logic                  is_sync;
    logic                  slots_full;
    logic [INTERVAL_W-1:0] now_ticks;
    logic [INTERVAL_W-1:0] then_ticks;
    logic [4:0]            slot_wide;

    assign gap        = coarse_time - last_coarse_reg;
    assign is_sync    = gap > COARSE_W'(sync_gap_reg);
    assign slots_full = next_slot_reg >= PTR_W'(CHANNELS);
    assign now_ticks  = {coarse_time[COARSE_W-FINE_W-1:0], FINE_W'(0)} + INTERVAL_W'(fine_time);
    assign then_ticks = {last_coarse_reg[COARSE_W-FINE_W-1:0], FINE_W'(0)}
                        + INTERVAL_W'(last_fine_reg);
    assign slot_wide  = 5'(next_slot_reg);
    assign wr_addr    = slot_wide[ADDR_W-1:0];

    always_comb begin
        sync_gap_next    = cfg_wr_en ? cfg_wr_data : sync_gap_reg;
        last_coarse_next = last_coarse_reg;
        last_fine_next   = last_fine_reg;
        in_sync_next     = in_sync_reg;
        next_slot_next   = next_slot_reg;
        sync_cnt_next    = sync_cnt_reg;

        evt.kind       = KIND_IGNORED;
        evt.slot_index = '0;
        evt.interval   = '0;
        evt.sync_total = sync_cnt_reg;
        evt.wr_en      = 1'b0;

        if (action == ACT_READ) begin
            evt.kind       = KIND_READ;
            evt.slot_index = read_slot;
        end else if (is_sync) begin
            evt.kind         = KIND_SYNC;
            evt.sync_total   = sync_cnt_reg + 1'b1;
            sync_cnt_next    = sync_cnt_reg + 1'b1;
            in_sync_next     = 1'b1;
            next_slot_next   = '0;
            last_coarse_next = coarse_time;
            last_fine_next   = fine_time;
        end else if (in_sync_reg && !slots_full) begin
            evt.kind         = KIND_STORED;
            evt.slot_index   = slot_wide[SLOT_W-1:0];
            evt.interval     = now_ticks - then_ticks;
            evt.wr_en        = accept;
            next_slot_next   = next_slot_reg + 1'b1;
            last_coarse_next = coarse_time;
            last_fine_next   = fine_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_gap_reg    <= SYNC_GAP_RESET;
            last_coarse_reg <= '0;
            last_fine_reg   <= '0;
            in_sync_reg     <= 1'b0;
            next_slot_reg   <= '0;
            sync_cnt_reg    <= '0;
        end else begin
            sync_gap_reg <= sync_gap_next;
            if (accept) begin
                last_coarse_reg <= last_coarse_next;
                last_fine_reg   <= last_fine_next;
                in_sync_reg     <= in_sync_next;
                next_slot_reg   <= next_slot_next;
                sync_cnt_reg    <= sync_cnt_next;
            end
        end
    end

endmodule

/* rtl/ppm_frame_decoder_top.sv */
// PPM frame decoder: accepts one word per cycle unless a stalled output backs up stage one.
// The interval RAM has one write and one read port.
// Results pass through the RAM read register and the output register on the way to m_tvalid.
// Reset (aresetn low, synchronous) clears the tracker, the output stage and the
// per-slot valid bits at once, so unwritten slots read as zero with no clearing pass.
`include "assert_macros.svh"
module ppm_frame_decoder_top
    import ppmfd_pkg::*;
#(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [GAP_W-1:0]      cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // coarse_time, fine_time, read_slot, zero pad
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // slot_index, pulse_interval, sync_total, zero pad
    output logic [1:0]            m_tuser    // event_kind
);

    localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                  accept;
    action_t               action;
    logic [COARSE_W-1:0]   coarse_time;
    logic [FINE_W-1:0]     fine_time;
    logic [SLOT_W-1:0]     read_slot;
    ppmfd_evt_t            evt;
    logic [ADDR_W-1:0]     wr_addr;
    logic [4:0]            rd_wide;
    logic                  rd_in_range;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  rd_hit;
    logic [INTERVAL_W-1:0] rd_data;
    logic                  out_free;

    logic [CHANNELS-1:0]   slot_valid_reg, slot_valid_next;
    logic                  st1_valid_reg,  st1_valid_next;
    ppmfd_evt_t            st1_evt_reg;
    logic                  st1_hit_reg;
    logic                  out_valid_reg,  out_valid_next;
    event_kind_t           out_kind_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [INTERVAL_W-1:0] out_interval_reg;
    logic [SYNC_W-1:0]     out_sync_reg;
    logic [INTERVAL_W-1:0] st1_interval;

    assign action      = action_t'(s_tuser);
    assign coarse_time = s_tdata[31:0];
    assign fine_time   = s_tdata[39:32];
    assign read_slot   = s_tdata[42:40];

    // Stage one may only hold a word while it waits for the output register.
    // No word is taken while reset is held, since the tracker would drop it.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = aresetn && (out_free || !st1_valid_reg);
    assign accept   = s_tvalid && s_tready;

    ppmfd_track #(
        .CHANNELS (CHANNELS),
        .ADDR_W   (ADDR_W)
    ) u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .action      (action),
        .coarse_time (coarse_time),
        .fine_time   (fine_time),
        .read_slot   (read_slot),
        .evt         (evt),
        .wr_addr     (wr_addr)
    );

    assign rd_wide     = 5'(read_slot);
    assign rd_in_range = rd_wide < 5'(CHANNELS);
    assign rd_addr     = rd_wide[ADDR_W-1:0];
    assign rd_hit      = rd_in_range && slot_valid_reg[rd_addr];

    // A write and a read never come from the same word, and a write lands at the edge that
    // accepts its word, before any later read is issued, so no forwarding is needed.
    ppmfd_ram #(
        .WIDTH  (INTERVAL_W),
        .DEPTH  (CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (evt.wr_en),
        .wr_addr (wr_addr),
        .wr_data (evt.interval),
        .rd_en   (accept && (action == ACT_READ)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        slot_valid_next = slot_valid_reg;
        if (evt.wr_en) begin
            slot_valid_next[wr_addr] = 1'b1;
        end
    end

    assign st1_interval = (st1_evt_reg.kind == KIND_READ)
                          ? (st1_hit_reg ? rd_data : '0)
                          : st1_evt_reg.interval;

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (out_free) begin
            st1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            st1_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            slot_valid_reg <= slot_valid_next;
            st1_valid_reg  <= st1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_evt_reg <= evt;
            st1_hit_reg <= rd_hit;
        end
        if (out_free && st1_valid_reg) begin
            out_kind_reg     <= st1_evt_reg.kind;
            out_slot_reg     <= st1_evt_reg.slot_index;
            out_interval_reg <= st1_interval;
            out_sync_reg     <= st1_evt_reg.sync_total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'd0, out_sync_reg, out_interval_reg, out_slot_reg};

    `AST_IMPL(a_stall_only_when_full, aclk, aresetn, !s_tready,
              st1_valid_reg && out_valid_reg && !m_tready,
              "input stalled although the pipeline has room")
    `AST_NEXT(a_rd_data_held, aclk, aresetn, st1_valid_reg && !out_free,
              $stable(rd_data), "RAM read data changed under a stalled word")
    `AST_IMPL(a_sync_fields_zero, aclk, aresetn,
              out_valid_reg && (out_kind_reg == KIND_SYNC || out_kind_reg == KIND_IGNORED),
              out_slot_reg == '0 && out_interval_reg == '0,
              "sync or ignored result carries a slot or an interval")
    `AST_IMPL(a_write_in_range, aclk, aresetn, evt.wr_en,
              32'(wr_addr) < CHANNELS && accept,
              "interval written outside the slot range or without a word")

endmodule
